>>> src/rgs_pkg.sv
// shared types and constants of the rgb gradient row stepper
// no dependencies; used by rgs_datapath, rgs_ctrl and the top module of the block
package rgs_pkg;

  localparam int NUM_CHAN  = 3;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 24;
  localparam int SPAN_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int INC_W     = CHAN_W + 1;
  localparam int CHAN_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_ROWS   = 2'd2;

  localparam logic [COLOR_W-1:0] START_COLOR_RST = 24'h000000;
  localparam logic [COLOR_W-1:0] END_COLOR_RST   = 24'hFFFFFF;
  localparam logic [SPAN_W-1:0]  SPAN_ROWS_RST   = 12'd256;

  localparam logic [CHAN_IDX_W-1:0] CHAN_RED   = 2'd0;
  localparam logic [CHAN_IDX_W-1:0] CHAN_GREEN = 2'd1;
  localparam logic [CHAN_IDX_W-1:0] CHAN_LAST  = 2'(NUM_CHAN - 1);

  typedef enum logic [1:0] {
    REGION_LEAD = 2'd0,
    REGION_BAND = 2'd1,
    REGION_HOLD = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FINISH,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic [CHAN_IDX_W-1:0] chan_idx;
    logic                  div_start;
    logic                  chan_store;
    logic                  restart_load;
    logic                  do_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } ctrl_status_t;

  function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                input logic [CHAN_IDX_W-1:0] idx);
    logic [CHAN_W-1:0] res;
    case (idx)
      CHAN_RED:   res = color[23:16];
      CHAN_GREEN: res = color[15:8];
      default:    res = color[7:0];
    endcase
    return res;
  endfunction

endpackage

>>> src/rgs_in_if.sv
// input channel of the gradient row stepper: one restart flag per beat
// depends on nothing
interface rgs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> src/rgs_out_if.sv
// output channel of the gradient row stepper: one row colour per beat
// depends on nothing
interface rgs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [1:0] region;
  logic       last_row;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output region, output last_row, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input region, input last_row, output ready);
endinterface

>>> src/rgs_div.sv
// iterative restoring divider, one quotient bit per cycle
// standalone; used by rgs_datapath for the restart setup
module rgs_div #(
  parameter int WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[WIDTH-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> src/rgs_datapath.sv
// datapath: config registers, per-channel step state, row counter and output register
// depends on rgs_pkg and rgs_div
module rgs_datapath #(
  parameter int ROW_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgs_pkg::COLOR_W-1:0]       cfg_data_i,
  input  rgs_pkg::ctrl_cmd_t                cmd_i,
  output rgs_pkg::ctrl_status_t             status_o,
  output logic [rgs_pkg::CHAN_W-1:0]        red_o,
  output logic [rgs_pkg::CHAN_W-1:0]        green_o,
  output logic [rgs_pkg::CHAN_W-1:0]        blue_o,
  output rgs_pkg::region_e                  region_o,
  output logic                              last_o
);

  localparam int NC = rgs_pkg::NUM_CHAN;
  localparam int CW = rgs_pkg::CHAN_W;
  localparam int IW = rgs_pkg::INC_W;

  logic [rgs_pkg::COLOR_W-1:0] start_q, end_q;
  logic [rgs_pkg::SPAN_W-1:0]  span_q;

  logic [CW-1:0]       level_q    [NC];
  logic [CW-1:0]       level_d    [NC];
  logic [ROW_BITS-1:0] interval_q [NC];
  logic [IW-1:0]       inc_q      [NC];
  logic [ROW_BITS-1:0] phase_q    [NC];
  logic [ROW_BITS-1:0] phase_d    [NC];
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [ROW_BITS-1:0] lead_q;
  logic [CW-1:0]       maxd_q;

  logic [CW-1:0]           red_q, green_q, blue_q;
  rgs_pkg::region_e        region_q, region_d;
  logic                    last_q, last_d;

  logic [ROW_BITS+rgs_pkg::SPAN_W-1:0] span_ext;
  logic [ROW_BITS-1:0] span_msk, span;
  logic [CW-1:0]       s_chan, e_chan, mag, maxd_new;
  logic                neg, span_gt;
  logic [ROW_BITS-1:0] dividend, divisor, quotient;
  logic                div_done;
  logic [ROW_BITS-1:0] band_end, lead_new;
  logic                in_span, band;

  // effective span: masked to the row counter, zero taken as one
  always_comb begin
    span_ext = {{ROW_BITS{1'b0}}, span_q};
    span_msk = span_ext[ROW_BITS-1:0];
    span     = (span_msk == '0) ? ROW_BITS'(1) : span_msk;
  end

  always_comb begin
    s_chan   = rgs_pkg::chan_of(start_q, cmd_i.chan_idx);
    e_chan   = rgs_pkg::chan_of(end_q, cmd_i.chan_idx);
    neg      = e_chan < s_chan;
    mag      = neg ? s_chan - e_chan : e_chan - s_chan;
    span_gt  = span > ROW_BITS'(mag);
    dividend = span_gt ? span : ROW_BITS'(mag);
    divisor  = span_gt ? ROW_BITS'(mag) : span;
    maxd_new = (cmd_i.chan_idx == rgs_pkg::CHAN_RED || mag > maxd_q) ? mag : maxd_q;
    lead_new = (ROW_BITS'(maxd_q) < span) ? (span - ROW_BITS'(maxd_q)) >> 1 : '0;
  end

  rgs_div #(
    .WIDTH (ROW_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.div_done = div_done;

  // one row step
  always_comb begin
    logic signed [IW:0] nxt;
    logic signed [IW:0] lim;
    logic [ROW_BITS-1:0] ph_inc;
    in_span  = row_q < span;
    band_end = span - lead_q;
    band     = 1'b0;
    last_d   = in_span && (row_q == span - ROW_BITS'(1));
    row_d    = in_span ? row_q + ROW_BITS'(1) : row_q;
    if (!in_span) begin
      region_d = rgs_pkg::REGION_HOLD;
    end else if (row_q < lead_q) begin
      region_d = rgs_pkg::REGION_LEAD;
    end else if (row_q < band_end) begin
      region_d = rgs_pkg::REGION_BAND;
      band     = 1'b1;
    end else begin
      region_d = rgs_pkg::REGION_HOLD;
    end
    for (int c = 0; c < NC; c++) begin
      level_d[c] = level_q[c];
      phase_d[c] = phase_q[c];
      nxt    = $signed({2'b00, level_q[c]}) + $signed({inc_q[c][IW-1], inc_q[c]});
      lim    = $signed({2'b00, rgs_pkg::chan_of(end_q, (rgs_pkg::CHAN_IDX_W)'(c))});
      ph_inc = phase_q[c] + ROW_BITS'(1);
      if (band && interval_q[c] != '0) begin
        if (phase_q[c] == '0) begin
          if (inc_q[c][IW-1] && nxt >= lim) begin
            level_d[c] = nxt[CW-1:0];
          end else if (!inc_q[c][IW-1] && inc_q[c] != '0 && nxt <= lim) begin
            level_d[c] = nxt[CW-1:0];
          end
        end
        phase_d[c] = (ph_inc == interval_q[c]) ? '0 : ph_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= rgs_pkg::START_COLOR_RST;
      end_q   <= rgs_pkg::END_COLOR_RST;
      span_q  <= rgs_pkg::SPAN_ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgs_pkg::CFG_START_COLOR: start_q <= cfg_data_i;
        rgs_pkg::CFG_END_COLOR:   end_q   <= cfg_data_i;
        rgs_pkg::CFG_SPAN_ROWS:   span_q  <= cfg_data_i[rgs_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      lead_q <= '0;
      maxd_q <= '0;
      for (int c = 0; c < NC; c++) begin
        level_q[c]    <= rgs_pkg::chan_of(rgs_pkg::START_COLOR_RST,
                                          (rgs_pkg::CHAN_IDX_W)'(c));
        interval_q[c] <= '0;
        inc_q[c]      <= '0;
        phase_q[c]    <= '0;
      end
    end else begin
      if (cmd_i.chan_store) begin
        maxd_q <= maxd_new;
        if (mag == '0) begin
          interval_q[cmd_i.chan_idx] <= '0;
          inc_q[cmd_i.chan_idx]      <= '0;
        end else if (span_gt) begin
          interval_q[cmd_i.chan_idx] <= quotient;
          inc_q[cmd_i.chan_idx]      <= neg ? {IW{1'b1}} : IW'(1);
        end else begin
          interval_q[cmd_i.chan_idx] <= ROW_BITS'(1);
          inc_q[cmd_i.chan_idx]      <= neg ? IW'(-$signed({1'b0, quotient[CW-1:0]}))
                                            : {1'b0, quotient[CW-1:0]};
        end
      end
      if (cmd_i.restart_load) begin
        lead_q <= lead_new;
        row_q  <= '0;
        for (int c = 0; c < NC; c++) begin
          level_q[c] <= rgs_pkg::chan_of(start_q, (rgs_pkg::CHAN_IDX_W)'(c));
          phase_q[c] <= '0;
        end
      end else if (cmd_i.do_step) begin
        row_q <= row_d;
        for (int c = 0; c < NC; c++) begin
          level_q[c] <= level_d[c];
          phase_q[c] <= phase_d[c];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_step) begin
      red_q    <= level_d[0];
      green_q  <= level_d[1];
      blue_q   <= level_d[2];
      region_q <= region_d;
      last_q   <= last_d;
    end
  end

  assign red_o    = red_q;
  assign green_o  = green_q;
  assign blue_o   = blue_q;
  assign region_o = region_q;
  assign last_o   = last_q;

endmodule

>>> src/rgs_ctrl.sv
// controller: sequences the restart setup and the row steps, owns the output valid
// depends on rgs_pkg
module rgs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_restart_i,
  input  logic                  out_ready_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  rgs_pkg::ctrl_status_t status_i,
  output rgs_pkg::ctrl_cmd_t    cmd_o
);

  rgs_pkg::state_e state_q, state_d;
  logic [rgs_pkg::CHAN_IDX_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rgs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_restart_i) begin
            state_d = rgs_pkg::ST_SETUP;
          end else if (!out_free) begin
            state_d = rgs_pkg::ST_STEP;
          end
        end
      end
      rgs_pkg::ST_SETUP: state_d = rgs_pkg::ST_DIV;
      rgs_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = (idx_q == rgs_pkg::CHAN_LAST) ? rgs_pkg::ST_FINISH : rgs_pkg::ST_SETUP;
        end
      end
      rgs_pkg::ST_FINISH: state_d = rgs_pkg::ST_STEP;
      rgs_pkg::ST_STEP: begin
        if (out_free) begin
          state_d = rgs_pkg::ST_IDLE;
        end
      end
      default: state_d = rgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    idx_d              = idx_q;
    cmd_o.chan_idx     = idx_q;
    cmd_o.div_start    = 1'b0;
    cmd_o.chan_store   = 1'b0;
    cmd_o.restart_load = 1'b0;
    cmd_o.do_step      = 1'b0;
    unique case (state_q)
      rgs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        if (in_valid_i && !in_restart_i && out_free) begin
          cmd_o.do_step = 1'b1;
        end
      end
      rgs_pkg::ST_SETUP: cmd_o.div_start = 1'b1;
      rgs_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.chan_store = 1'b1;
          idx_d            = idx_q + 2'd1;
        end
      end
      rgs_pkg::ST_FINISH: cmd_o.restart_load = 1'b1;
      rgs_pkg::ST_STEP:   cmd_o.do_step = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.do_step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgs_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/rgb_gradient_row_stepper.sv
// rgb gradient row stepper: one colour per row beat, restart reloads the gradient
// a plain row beat's result is registered in the output register, one beat per cycle while out_ready keeps up
// restart beat: three runs of the shared divider, one per channel, before rows step again
// the output register lets the next beat in while a result waits
// reset: async active low, config to start 0, end 0xFFFFFF, span 256, state cleared
module rgb_gradient_row_stepper #(
  parameter int ROW_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rgs_in_if.sink                        in_i,
  rgs_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [rgs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgs_pkg::COLOR_W-1:0]   cfg_data_i
);

  rgs_pkg::ctrl_cmd_t    cmd;
  rgs_pkg::ctrl_status_t status;
  rgs_pkg::region_e      region;

  rgs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .out_ready_i  (out_o.ready),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rgs_datapath #(
    .ROW_BITS (ROW_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .red_o      (out_o.red_out),
    .green_o    (out_o.green_out),
    .blue_o     (out_o.blue_out),
    .region_o   (region),
    .last_o     (out_o.last_row)
  );

  assign out_o.region = region;

endmodule

>>> tb/rgs_row_checker.sv
// row checker for the rgb gradient row stepper: watches both channels and the config port,
// predicts each row colour and compares it with the output beats
// depends on rgs_pkg, rgs_in_if and rgs_out_if
module rgs_row_checker
  import rgs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgs_in_if                    in_mon,
  rgs_out_if                   out_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COLOR_W-1:0]   cfg_data_i,
  output int                   err_cnt_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    region_e           region;
    logic              last;
  } row_color_t;

  logic [COLOR_W-1:0] start_q;
  logic [COLOR_W-1:0] end_q;
  logic [SPAN_W-1:0]  span_q;
  int unsigned        row_cnt;
  int unsigned        lead_cnt;
  int unsigned        band_cnt;
  logic [CHAN_W-1:0]  level[NUM_CHAN];
  int unsigned        ivl[NUM_CHAN];
  int                 inc[NUM_CHAN];
  row_color_t         expected_rows[$];

  function automatic int unsigned color_chan(input logic [COLOR_W-1:0] col, input int c);
    return col[COLOR_W-1-CHAN_W*c -: CHAN_W];
  endfunction

  function automatic void reload_gradient(input int unsigned span);
    int unsigned s, e, mag, maxd;
    maxd = 0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s = color_chan(start_q, c);
      e = color_chan(end_q, c);
      mag = (e < s) ? s - e : e - s;
      level[c] = s[CHAN_W-1:0];
      if (mag > maxd) maxd = mag;
      if (mag == 0) begin
        ivl[c] = 0;
        inc[c] = 0;
      end else if (span > mag) begin
        ivl[c] = span / mag;
        inc[c] = (e < s) ? -1 : 1;
      end else begin
        ivl[c] = 1;
        inc[c] = (e < s) ? -int'(mag / span) : int'(mag / span);
      end
    end
    lead_cnt = (maxd < span) ? (span - maxd) / 2 : 0;
    row_cnt = 0;
    band_cnt = 0;
  endfunction

  function automatic row_color_t next_row_color(input logic restart);
    int unsigned span, r;
    int          nxt, lim;
    row_color_t  rc;
    span = (span_q == '0) ? 1 : span_q;
    if (restart) reload_gradient(span);
    rc.last = 1'b0;
    if (row_cnt >= span) begin
      rc.region = REGION_HOLD;
    end else begin
      r = row_cnt;
      if (r < lead_cnt) begin
        rc.region = REGION_LEAD;
      end else if (r < span - lead_cnt) begin
        rc.region = REGION_BAND;
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (ivl[c] != 0 && (band_cnt % ivl[c]) == 0) begin
            lim = color_chan(end_q, c);
            nxt = int'(level[c]) + inc[c];
            if ((inc[c] < 0 && nxt >= lim) || (inc[c] > 0 && nxt <= lim)) level[c] = nxt[7:0];
          end
        end
        band_cnt = (band_cnt + 1) % (1 << SPAN_W);
      end else begin
        rc.region = REGION_HOLD;
      end
      if (r == span - 1) rc.last = 1'b1;
      row_cnt = r + 1;
    end
    rc.red = level[0];
    rc.green = level[1];
    rc.blue = level[2];
    return rc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_color_t want, got;
    if (!rst_ni) begin
      start_q = START_COLOR_RST;
      end_q = END_COLOR_RST;
      span_q = SPAN_ROWS_RST;
      row_cnt = 0;
      lead_cnt = 0;
      band_cnt = 0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        level[c] = color_chan(START_COLOR_RST, c);
        ivl[c] = 0;
        inc[c] = 0;
      end
      expected_rows.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_COLOR: start_q = cfg_data_i;
          CFG_END_COLOR:   end_q = cfg_data_i;
          CFG_SPAN_ROWS:   span_q = cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) expected_rows.push_back(next_row_color(in_mon.restart));
      if (out_mon.valid && out_mon.ready) begin
        got.red = out_mon.red_out;
        got.green = out_mon.green_out;
        got.blue = out_mon.blue_out;
        got.region = region_e'(out_mon.region);
        got.last = out_mon.last_row;
        if (expected_rows.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= MAX_REPORTS)
            $display("%0t: unexpected row beat r=%0d g=%0d b=%0d region=%0d last=%0d",
                     $realtime, got.red, got.green, got.blue, got.region, got.last);
        end else begin
          want = expected_rows.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.region !== want.region || got.last !== want.last) begin
            err_cnt_o++;
            if (err_cnt_o <= MAX_REPORTS)
              $display("%0t: row mismatch exp r=%0d g=%0d b=%0d region=%0d last=%0d, got r=%0d g=%0d b=%0d region=%0d last=%0d",
                       $realtime, want.red, want.green, want.blue, want.region, want.last,
                       got.red, got.green, got.blue, got.region, got.last);
          end
        end
      end
      pending_o = expected_rows.size();
    end
  end

endmodule

>>> tb/testbench.sv
// top of the rgb gradient row stepper testbench: clock, reset, config writes, row beats
// and random back-pressure; the verdict comes from rgs_row_checker
// depends on rgs_pkg, rgs_in_if, rgs_out_if, rgs_row_checker and the block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rgs_pkg::*;

  localparam int ROW_TARGET    = 1050;
  localparam int CALM_FROM     = 900;
  localparam int LONG_HOLD     = 120;
  localparam int SETTLE_CYCLES = 3 * 12 + 12;
  localparam int STALL_LIMIT   = 4000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COLOR_W-1:0]   cfg_data;
  int                   err_cnt;
  int                   pending;
  int                   rows_sent = 0;
  int                   quiet_cycles = 0;
  bit                   gaps_on = 1'b1;
  bit                   hold_req = 1'b0;

  rgs_in_if  in_if ();
  rgs_out_if out_if ();

  rgb_gradient_row_stepper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rgs_row_checker row_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[rgb_gradient_row_stepper] ERROR");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : row_sink
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk_i);
      end
    end
  end

  task automatic send_row(input logic restart);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    rows_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_rows(input int n, input logic first_restart);
    for (int i = 0; i < n; i++) send_row(i == 0 ? first_restart : ($urandom_range(0, 29) == 0));
  endtask

  task automatic drain_rows();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  task automatic program_gradient(input logic [2:0] which, input logic [COLOR_W-1:0] c_start,
                                  input logic [COLOR_W-1:0] c_end,
                                  input logic [SPAN_W-1:0] span_val);
    drain_rows();
    if (which[0]) write_reg(CFG_START_COLOR, c_start);
    if (which[1]) write_reg(CFG_END_COLOR, c_end);
    if (which[2]) write_reg(CFG_SPAN_ROWS, COLOR_W'(span_val));
    cfg_we <= 1'b0;
  endtask

  initial begin : row_source
    logic [COLOR_W-1:0] c_start, c_end;
    logic [SPAN_W-1:0]  span_val;
    logic [2:0]         which;
    int                 phase;
    int                 n;
    in_if.valid = 1'b0;
    in_if.restart = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_START_COLOR;
    cfg_data = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // rows before any restart, then the corner gradients
    run_rows(3, 1'b0);
    program_gradient(3'b111, 24'h000000, 24'hFFFFFF, 12'd0);
    run_rows(3, 1'b1);
    program_gradient(3'b111, 24'h00FF80, 24'hFF00FF, 12'd255);
    run_rows(5, 1'b1);
    program_gradient(3'b111, 24'h102030, 24'hF0A010, 12'd3);
    run_rows(5, 1'b1);
    program_gradient(3'b111, 24'h808080, 24'h808080, 12'd6);
    run_rows(4, 1'b1);
    program_gradient(3'b111, 24'hFFFFFF, 24'h000000, 12'd4095);
    run_rows(3, 1'b1);

    phase = 0;
    while (rows_sent < ROW_TARGET) begin
      phase++;
      which = (phase <= 2) ? 3'b111 : 3'($urandom_range(1, 7));
      c_start = COLOR_W'($urandom);
      c_end = COLOR_W'($urandom);
      case ($urandom_range(0, 7))
        0: begin
          c_start = 24'h000000;
          c_end = 24'hFFFFFF;
        end
        1: begin
          c_start = 24'hFFFFFF;
          c_end = 24'h000000;
        end
        2: c_end[15:8] = c_start[15:8];
        3, 4: c_end = {c_start[23:16] + 8'($urandom_range(0, 9)),
                       c_start[15:8] - 8'($urandom_range(0, 9)),
                       c_start[7:0] + 8'($urandom_range(0, 20))};
        default: ;
      endcase
      case ($urandom_range(0, 15))
        0:       span_val = 12'd4095;
        1:       span_val = 12'd0;
        2, 3:    span_val = SPAN_W'($urandom_range(41, 600));
        default: span_val = SPAN_W'($urandom_range(1, 40));
      endcase
      program_gradient(which, c_start, c_end, span_val);
      gaps_on = (rows_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(10, 60);
      if (phase == 3) begin
        // the restart keeps the block busy until the long hold has begun
        hold_req = 1'b1;
        run_rows(60, 1'b1);
      end else if (phase == 5) begin
        run_rows(n, 1'b1);
        drain_rows();
        run_rows(n, 1'b0);
      end else begin
        run_rows(n, $urandom_range(0, 9) != 0);
      end
    end

    drain_rows();
    gaps_on = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("[rgb_gradient_row_stepper] OK");
    end else begin
      $display("[rgb_gradient_row_stepper] ERROR");
    end
    $finish;
  end

endmodule
